[rtl/core/bust_pkg.sv]
// ----------------------------------------------------------------------------
// bust_pkg
// Shared types and constants for the bounded unordered set table: operation
// codes, default sizes and the input and result transaction structs.
// ----------------------------------------------------------------------------
package bust_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int FUNC_W        = 2;
	localparam int ITEM_VALUE_W  = 32;
	localparam int ENTRY_COUNT_W = 5;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [ITEM_VALUE_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic                     hit;
		logic                     refused_full;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} out_item_t;

endpackage

[rtl/core/bounded_unordered_set_table.sv]
// ----------------------------------------------------------------------------
// bounded_unordered_set_table
// Fixed-capacity set of distinct values with insert, erase and query.
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one operation (func, item_value) per
//   transaction; out_valid/out_stall/out_data return exactly one result per
//   operation (hit, refused_full, entry_count after the operation).
//   each operation scans the stored entries one per cycle through a single
//   comparator reading the entry memory; a hit ends the scan early, and an
//   erase that hits then moves the last entry into the freed slot.
//   the next operation is accepted in the cycle after the result moves out,
//   so the block never works on two operations at once.
//   in_stall stays high from acceptance until the result moves into the
//   output register; the next operation is then taken while that result
//   waits. a stalled result holds in the output register, and a second
//   finished result waits in the sequencer until the register frees up.
//   reset clears the count, so the table comes up empty; entry memory is
//   not cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_unordered_set_table
	import bust_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [VALUE_WIDTH-1:0] in_val;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   res_valid;
	logic                   res_ready;
	out_item_t              res;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	generate
		if (VALUE_WIDTH <= ITEM_VALUE_W) begin : g_val_trunc
			assign in_val = in_data.item_value[VALUE_WIDTH-1:0];
		end else begin : g_val_ext
			assign in_val = {{(VALUE_WIDTH-ITEM_VALUE_W){1'b0}}, in_data.item_value};
		end
	endgenerate

	bust_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_func   (in_data.func),
		.in_val    (in_val),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	bust_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (VALUE_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// output register frees up when empty or when its transaction completes
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/core/bust_mem.sv]
// ----------------------------------------------------------------------------
// bust_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bust_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/bust_seq.sv]
// ----------------------------------------------------------------------------
// bust_seq
// Sequencer for the set table: scans stored entries one per cycle through a
// single equality comparator, then appends, moves the last entry or reports.
// ----------------------------------------------------------------------------
module bust_seq
	import bust_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [FUNC_W-1:0]      in_func,
	input  logic [VALUE_WIDTH-1:0] in_val,
	output logic                   res_valid,
	input  logic                   res_ready,
	output out_item_t              res,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	input  logic [VALUE_WIDTH-1:0] rd_data,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [VALUE_WIDTH-1:0] wr_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_LAST   = 3'd2;
	localparam logic [2:0] ST_RESULT = 3'd3;

	logic [2:0]             state_q;
	logic [FUNC_W-1:0]      op_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          pend_idx_q;
	logic [AW-1:0]          slot_q;
	logic                   pend_q;
	logic                   hit_q;
	logic                   refused_q;

	logic          match;
	logic          scan_more;
	logic          scan_miss;
	logic          full;
	logic [CW-1:0] cnt_m1;

	assign match     = pend_q && (rd_data == val_q);
	assign scan_more = idx_q < cnt_q;
	assign scan_miss = !match && !scan_more && !pend_q;
	assign full      = cnt_q == CW'(TABLE_DEPTH);
	assign cnt_m1    = cnt_q - 1'b1;

	assign in_stall = state_q != ST_IDLE;

	// read port: scan reads, or the last entry once an erase has found its slot
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		if (state_q == ST_SCAN) begin
			if (match) begin
				rd_en   = op_q == FUNC_ERASE;
				rd_addr = cnt_m1[AW-1:0];
			end else if (scan_more) begin
				rd_en = 1'b1;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = val_q;
		if (state_q == ST_SCAN) begin
			wr_en = scan_miss && (op_q == FUNC_INSERT) && !full;
		end else if (state_q == ST_LAST) begin
			wr_en   = 1'b1;
			wr_addr = slot_q;
			wr_data = rd_data;
		end
	end

	assign res_valid            = state_q == ST_RESULT;
	assign res.hit              = hit_q;
	assign res.refused_full     = refused_q;
	assign res.entry_count      = ENTRY_COUNT_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			hit_q     <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q      <= in_func;
						val_q     <= in_val;
						idx_q     <= '0;
						pend_q    <= 1'b0;
						hit_q     <= 1'b0;
						refused_q <= 1'b0;
						if (in_func == FUNC_INSERT || in_func == FUNC_ERASE ||
							in_func == FUNC_QUERY) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_SCAN: begin
					pend_q <= 1'b0;
					if (match) begin
						hit_q  <= 1'b1;
						slot_q <= pend_idx_q;
						if (op_q == FUNC_ERASE) begin
							cnt_q   <= cnt_m1;
							state_q <= ST_LAST;
						end else begin
							state_q <= ST_RESULT;
						end
					end else if (scan_more) begin
						pend_q     <= 1'b1;
						pend_idx_q <= idx_q[AW-1:0];
						idx_q      <= idx_q + 1'b1;
					end else if (!pend_q) begin
						// value absent
						if (op_q == FUNC_INSERT) begin
							if (full) begin
								refused_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						state_q <= ST_RESULT;
					end
				end
				ST_LAST: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/bounded_unordered_set_table_tb.sv]
// ----------------------------------------------------------------------------
// bounded_unordered_set_table_tb
// Self-checking testbench for the bounded unordered set table. A behavioral
// copy of the set, updated at every accepted operation, predicts hit,
// refused_full and entry_count, and each returned transaction is checked
// against the oldest prediction. Directed cases cover the empty and full
// table, then random traffic over a small value pool runs under several
// idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module bounded_unordered_set_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bust_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam int POOL_SIZE     = 20;
	localparam int HOLD_CYCLES   = 120;
	localparam int SETTLE_CYCLES = 30;
	localparam int TIMEOUT_NS    = 4_000_000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	// behavioral copy of the table contents
	logic [ITEM_VALUE_W-1:0] set_values [DEF_TABLE_DEPTH];
	int                      set_size = 0;

	out_item_t               pending_results [$];
	logic [ITEM_VALUE_W-1:0] value_pool [POOL_SIZE];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int hold_left          = 0;

	int mismatch_count  = 0;
	int results_checked = 0;
	int hit_count       = 0;
	int refusal_count   = 0;
	int op_count [4]    = '{0, 0, 0, 0};

	bounded_unordered_set_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	// updates the set copy and returns the result the block should give
	function automatic out_item_t apply_set_op(input in_item_t item);
		out_item_t res;
		int        slot;
		res  = '0;
		slot = set_size;
		for (int k = set_size - 1; k >= 0; k--)
			if (set_values[k] == item.item_value)
				slot = k;
		case (item.func)
			FUNC_INSERT: begin
				if (slot < set_size)
					res.hit = 1'b1;
				else if (set_size >= DEF_TABLE_DEPTH)
					res.refused_full = 1'b1;
				else begin
					set_values[set_size] = item.item_value;
					set_size++;
				end
			end
			FUNC_ERASE: begin
				if (slot < set_size) begin
					res.hit = 1'b1;
					set_size--;
					set_values[slot] = set_values[set_size];
				end
			end
			FUNC_QUERY: begin
				res.hit = (slot < set_size);
			end
			default: begin
			end
		endcase
		res.entry_count = ENTRY_COUNT_W'(set_size);
		op_count[item.func]++;
		hit_count     += res.hit;
		refusal_count += res.refused_full;
		return res;
	endfunction

	// receiver: random stall, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	task automatic compare_field(input string field, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (got_v !== want_v) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field,
				want_v, got_v);
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: unexpected transaction, expected none actual %b/%b/%0d",
					$time, out_data.hit, out_data.refused_full, out_data.entry_count);
			end else begin
				want = pending_results.pop_front();
				compare_field("hit", want.hit, out_data.hit);
				compare_field("refused_full", want.refused_full, out_data.refused_full);
				compare_field("entry_count", want.entry_count, out_data.entry_count);
			end
		end
	end

	// valid is left high after acceptance; the next call or a drain moves it
	task automatic send_op(input logic [FUNC_W-1:0] func,
		input logic [ITEM_VALUE_W-1:0] value);
		in_item_t item;
		item.func       = func;
		item.item_value = value;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(apply_set_op(item));
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_op();
		int                      roll;
		logic [FUNC_W-1:0]       func;
		logic [ITEM_VALUE_W-1:0] value;
		roll = $urandom_range(99);
		if (roll < 40)
			func = FUNC_INSERT;
		else if (roll < 65)
			func = FUNC_ERASE;
		else if (roll < 95)
			func = FUNC_QUERY;
		else
			func = FUNC_UNUSED;
		// mostly pool values so hits and a full table are common
		if ($urandom_range(9) == 0)
			value = $urandom;
		else
			value = value_pool[$urandom_range(POOL_SIZE - 1)];
		send_op(func, value);
	endtask

	task automatic random_burst(input int count, input int idle_pct, input int stall_pct);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count)
			send_random_op();
	endtask

	task automatic test_basic_ops();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_op(FUNC_QUERY, '0);
		send_op(FUNC_ERASE, '0);
		send_op(FUNC_UNUSED, '1);
		send_op(FUNC_INSERT, '0);
		send_op(FUNC_INSERT, '1);
		send_op(FUNC_INSERT, '0);
		send_op(FUNC_QUERY, '1);
		// erase of the last entry
		send_op(FUNC_ERASE, '1);
		send_op(FUNC_INSERT, 32'h5555_5555);
		send_op(FUNC_INSERT, 32'hAAAA_AAAA);
		// erase of the first entry pulls the last one into its slot
		send_op(FUNC_ERASE, '0);
		send_op(FUNC_QUERY, 32'hAAAA_AAAA);
		wait_until_drained();
	endtask

	task automatic test_capacity_limit();
		for (int k = 0; k < DEF_TABLE_DEPTH; k++)
			send_op(FUNC_INSERT, 32'h1000_0000 + k);
		send_op(FUNC_INSERT, 32'hDEAD_BEEF);
		send_op(FUNC_INSERT, 32'hAAAA_AAAA);
		send_op(FUNC_QUERY, 32'hDEAD_BEEF);
		send_op(FUNC_ERASE, 32'h1000_0003);
		send_op(FUNC_INSERT, 32'hDEAD_BEEF);
		wait_until_drained();
	endtask

	task automatic test_random_traffic();
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++)
			value_pool[k] = $urandom;
		random_burst(110, 0, 0);
		random_burst(110, 59, 0);
		random_burst(110, 0, 59);
		random_burst(110, 11, 11);
		wait_until_drained();
	endtask

	// long output hold-off with the sender pushing, so the input stalls
	task automatic test_backpressure();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_left          = HOLD_CYCLES;
		repeat (8)
			send_random_op();
		wait_until_drained();
		repeat (6)
			send_random_op();
		wait_until_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_capacity_limit();
		test_random_traffic();
		test_backpressure();

		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d inserts, %0d erases, %0d queries, %0d unused codes",
			op_count[FUNC_INSERT], op_count[FUNC_ERASE], op_count[FUNC_QUERY],
			op_count[FUNC_UNUSED]);
		$display("checked %0d results: %0d hits, %0d full-table refusals, %0d mismatches",
			results_checked, hit_count, refusal_count, mismatch_count);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout at %0t ns, %0d results outstanding", $time,
			pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
